@@ design/gtg_pkg.sv @@
// shared types and constants for the go-to-goal steering block
package gtg_pkg;

    // vectoring angle stages and integer square root stages
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_STEPS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int SQRT_STEPS    = 16;
    localparam int ITER_STAGES   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

    // field widths
    localparam int POS_W  = 15;
    localparam int HEAD_W = 16;
    localparam int GAIN_W = 16;
    localparam int LIN_W  = 20;
    localparam int ANG_W  = 22;

    // internal widths
    localparam int DIFF_W  = POS_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int TOLSQ_W = 2 * POS_W;
    localparam int CW      = 35;
    localparam int ZW      = 24;
    localparam int RW      = 17;
    localparam int ERR_W   = 18;
    localparam int LP_W    = GAIN_W + DIFF_W;
    localparam int AP_W    = GAIN_W + 1 + ERR_W;
    localparam int AS_W    = AP_W + 1 - 12;

    // port widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - LIN_W - ANG_W;
    localparam int IN_PAD_W   = IN_DATA_W - 2 * POS_W - HEAD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X       = 3'd0,
        REG_GOAL_Y       = 3'd1,
        REG_TOLERANCE    = 3'd2,
        REG_GAIN_LINEAR  = 3'd3,
        REG_GAIN_ANGULAR = 3'd4
    } cfg_reg_t;

    localparam logic [POS_W-1:0]  GOAL_X_RESET       = 15'd2048;
    localparam logic [POS_W-1:0]  GOAL_Y_RESET       = 15'd2048;
    localparam logic [POS_W-1:0]  TOLERANCE_RESET    = 15'd20;
    localparam logic [GAIN_W-1:0] GAIN_LINEAR_RESET  = 16'd4096;
    localparam logic [GAIN_W-1:0] GAIN_ANGULAR_RESET = 16'd16384;

    localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294198;
    localparam logic signed [RW-1:0] PI_Q13 = 17'sd25736;

    localparam logic [LIN_W-1:0]        LIN_MAX = {LIN_W{1'b1}};
    localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

    // atan(2^-i) in Q.20 radians
    localparam logic [ZW-1:0] ATAN_Q20 [ATAN_LEN] = '{
        24'd823550, 24'd486170, 24'd256879, 24'd130396,
        24'd65451,  24'd32757,  24'd16383,  24'd8192,
        24'd4096,   24'd2048,   24'd1024,   24'd512,
        24'd256,    24'd128,    24'd64,     24'd32,
        24'd16,     24'd8,      24'd4,      24'd2,
        24'd1,      24'd0,      24'd0,      24'd0
    };

endpackage

@@ design/go_to_goal_steering.sv @@
// go-to-goal steering: distance and bearing to a goal, proportional speed and turn commands
//
// One pose request per clock cycle while s_axis_tready is high. After the offset and squared
// distance stages come the iteration stages (sixteen by default), each holding one vectoring
// CORDIC step for the bearing and one restoring square-root step for the distance, followed
// by the gain multipliers and saturation. Every stage stalls only while the stage after it
// is full, so a bubble in the pipeline is squeezed out and a waiting result stops new
// requests only once every stage holds one. The user must write the configuration registers
// through cfg_wen/cfg_index/cfg_wdata only while no request is in flight; the block itself
// does not enforce this.
module go_to_goal_steering
    import gtg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pose_x [14:0], pose_y [29:15], pose_heading [45:30], zero fill [47:46]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // linear_velocity [19:0], angular_velocity [41:20], zero fill [47:42]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // reached [0]
    output logic                  m_axis_tuser
);

    // configuration
    logic [POS_W-1:0]   goal_x_reg, goal_y_reg, tolerance_reg;
    logic [GAIN_W-1:0]  gain_linear_reg, gain_angular_reg;
    logic [TOLSQ_W-1:0] tol_sq_reg, tol_sq_next;

    // input fields
    logic [POS_W-1:0]         pose_x, pose_y;
    logic signed [HEAD_W-1:0] pose_heading;

    // stage a: offsets
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] a_dx_reg, a_dy_reg, a_dx_next, a_dy_next;
    logic signed [HEAD_W-1:0] a_hd_reg;

    // stage b: squared distance and pre-rotation
    logic                     b_valid_reg;
    logic [SQ_W-1:0]          b_sq_reg, b_sq_next;
    logic signed [SQ_W-1:0]   dx_sq, dy_sq;
    logic signed [CW-1:0]     b_x_reg, b_y_reg, b_x_next, b_y_next;
    logic signed [ZW-1:0]     b_z_reg, b_z_next;
    logic signed [HEAD_W-1:0] b_hd_reg;

    // iteration stages
    logic                     it_valid_reg   [0:ITER_STAGES];
    logic                     it_reached_reg [0:ITER_STAGES];
    logic signed [CW-1:0]     it_x_reg       [0:ITER_STAGES];
    logic signed [CW-1:0]     it_y_reg       [0:ITER_STAGES];
    logic signed [ZW-1:0]     it_z_reg       [0:ITER_STAGES];
    logic [SQ_W-1:0]          it_rem_reg     [0:ITER_STAGES];
    logic [SQ_W-1:0]          it_root_reg    [0:ITER_STAGES];
    logic signed [HEAD_W-1:0] it_hd_reg      [0:ITER_STAGES];
    logic signed [CW-1:0]     it_x_next      [1:ITER_STAGES];
    logic signed [CW-1:0]     it_y_next      [1:ITER_STAGES];
    logic signed [ZW-1:0]     it_z_next      [1:ITER_STAGES];
    logic [SQ_W-1:0]          it_rem_next    [1:ITER_STAGES];
    logic [SQ_W-1:0]          it_root_next   [1:ITER_STAGES];
    logic                     it_en          [0:ITER_STAGES];
    logic                     reached_next;

    // stage d: bearing error and linear product
    logic                     d_valid_reg, d_reached_reg;
    logic [LP_W-1:0]          d_lin_prod_reg, d_lin_prod_next;
    logic signed [ERR_W-1:0]  d_err_reg, d_err_next;
    logic signed [ZW-1:0]     z_round;
    logic signed [ZW-1:0]     z_shift;
    logic signed [RW-1:0]     bearing;

    // stage e: angular product and linear saturation
    logic                     e_valid_reg, e_reached_reg;
    logic [LIN_W-1:0]         e_lin_reg, e_lin_next;
    logic signed [AP_W-1:0]   e_ang_prod_reg, e_ang_prod_next;
    logic [LP_W:0]            lin_round;
    logic [LP_W-12:0]         lin_shift;

    // stage f: output register
    logic                     out_valid_reg, out_reached_reg;
    logic [LIN_W-1:0]         out_lin_reg, out_lin_next;
    logic signed [ANG_W-1:0]  out_ang_reg, out_ang_next;
    logic signed [AP_W:0]     ang_round;
    logic signed [AS_W-1:0]   ang_shift;

    logic en_a, en_b, en_d, en_e, en_f;

    assign pose_x       = s_axis_tdata[POS_W-1:0];
    assign pose_y       = s_axis_tdata[2*POS_W-1:POS_W];
    assign pose_heading = s_axis_tdata[2*POS_W+HEAD_W-1:2*POS_W];

    // a stage loads when it is empty or the next one moves
    always_comb
    begin
        en_f = !out_valid_reg || m_axis_tready;
        en_e = !e_valid_reg || en_f;
        en_d = !d_valid_reg || en_e;
        it_en[ITER_STAGES] = !it_valid_reg[ITER_STAGES] || en_d;
        for (int k = ITER_STAGES - 1; k >= 0; k--)
        begin
            it_en[k] = !it_valid_reg[k] || it_en[k+1];
        end
        en_b = !b_valid_reg || it_en[0];
        en_a = !a_valid_reg || en_b;
    end

    assign s_axis_tready = en_a;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg       <= GOAL_X_RESET;
            goal_y_reg       <= GOAL_Y_RESET;
            tolerance_reg    <= TOLERANCE_RESET;
            gain_linear_reg  <= GAIN_LINEAR_RESET;
            gain_angular_reg <= GAIN_ANGULAR_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GOAL_X:       goal_x_reg       <= cfg_wdata[POS_W-1:0];
                REG_GOAL_Y:       goal_y_reg       <= cfg_wdata[POS_W-1:0];
                REG_TOLERANCE:    tolerance_reg    <= cfg_wdata[POS_W-1:0];
                REG_GAIN_LINEAR:  gain_linear_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_ANGULAR: gain_angular_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign tol_sq_next = tolerance_reg * tolerance_reg;

    always_ff @(posedge clk)
    begin
        tol_sq_reg <= tol_sq_next;
    end

    // stage a
    assign a_dx_next = $signed({1'b0, goal_x_reg}) - $signed({1'b0, pose_x});
    assign a_dy_next = $signed({1'b0, goal_y_reg}) - $signed({1'b0, pose_y});

    // stage b
    always_comb
    begin
        dx_sq     = a_dx_reg * a_dx_reg;
        dy_sq     = a_dy_reg * a_dy_reg;
        b_sq_next = $unsigned(dx_sq) + $unsigned(dy_sq);
        b_x_next  = CW'(a_dx_reg) <<< 16;
        b_y_next  = CW'(a_dy_reg) <<< 16;
        b_z_next  = '0;
        // left half plane: rotate by pi first
        if (a_dx_reg < 0)
        begin
            b_x_next = -b_x_next;
            b_y_next = -b_y_next;
            b_z_next = (a_dy_reg >= 0) ? PI_Q20 : -PI_Q20;
        end
    end

    assign reached_next = b_sq_reg <= SQ_W'(tol_sq_reg);

    // one cordic step and one square root step per stage
    for (genvar k = 0; k < ITER_STAGES; k++)
    begin : g_iter
        if (k < CORDIC_STEPS)
        begin : g_cordic
            logic signed [CW-1:0] xs, ys;
            logic signed [ZW-1:0] step_angle;

            assign xs         = it_x_reg[k] >>> k;
            assign ys         = it_y_reg[k] >>> k;
            assign step_angle = $signed(ATAN_Q20[k]);

            always_comb
            begin
                if (it_y_reg[k] > 0)
                begin
                    it_x_next[k+1] = it_x_reg[k] + ys;
                    it_y_next[k+1] = it_y_reg[k] - xs;
                    it_z_next[k+1] = it_z_reg[k] + step_angle;
                end
                else
                begin
                    it_x_next[k+1] = it_x_reg[k] - ys;
                    it_y_next[k+1] = it_y_reg[k] + xs;
                    it_z_next[k+1] = it_z_reg[k] - step_angle;
                end
            end
        end
        else
        begin : g_cordic_pass
            assign it_x_next[k+1] = it_x_reg[k];
            assign it_y_next[k+1] = it_y_reg[k];
            assign it_z_next[k+1] = it_z_reg[k];
        end

        if (k < SQRT_STEPS)
        begin : g_sqrt
            localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            logic [SQ_W-1:0] trial;

            assign trial = it_root_reg[k] | SQ_BIT;

            always_comb
            begin
                if (it_rem_reg[k] >= trial)
                begin
                    it_rem_next[k+1]  = it_rem_reg[k] - trial;
                    it_root_next[k+1] = (it_root_reg[k] >> 1) | SQ_BIT;
                end
                else
                begin
                    it_rem_next[k+1]  = it_rem_reg[k];
                    it_root_next[k+1] = it_root_reg[k] >> 1;
                end
            end
        end
        else
        begin : g_sqrt_pass
            assign it_rem_next[k+1]  = it_rem_reg[k];
            assign it_root_next[k+1] = it_root_reg[k];
        end
    end

    // stage d: round bearing to Q3.13 and clamp
    always_comb
    begin
        z_round = it_z_reg[ITER_STAGES] + ZW'(64);
        z_shift = z_round >>> 7;
        bearing = z_shift[RW-1:0];
        if (bearing > PI_Q13)
        begin
            bearing = PI_Q13;
        end
        else if (bearing < -PI_Q13)
        begin
            bearing = -PI_Q13;
        end
        d_err_next      = ERR_W'(bearing) - ERR_W'(it_hd_reg[ITER_STAGES]);
        d_lin_prod_next = gain_linear_reg * it_root_reg[ITER_STAGES][DIFF_W-1:0];
    end

    // stage e
    always_comb
    begin
        lin_round       = {1'b0, d_lin_prod_reg} + (LP_W+1)'(2048);
        lin_shift       = lin_round[LP_W:12];
        e_lin_next      = (lin_shift > (LP_W-11)'(LIN_MAX)) ? LIN_MAX : lin_shift[LIN_W-1:0];
        e_ang_prod_next = $signed({1'b0, gain_angular_reg}) * d_err_reg;
    end

    // stage f: round, saturate, zero out once the goal is reached
    always_comb
    begin
        ang_round = (AP_W+1)'(e_ang_prod_reg) + (AP_W+1)'(2048);
        ang_shift = AS_W'(ang_round >>> 12);
        if (ang_shift > AS_W'(ANG_MAX))
        begin
            out_ang_next = ANG_MAX;
        end
        else if (ang_shift < AS_W'(ANG_MIN))
        begin
            out_ang_next = ANG_MIN;
        end
        else
        begin
            out_ang_next = ang_shift[ANG_W-1:0];
        end
        out_lin_next = e_lin_reg;
        if (e_reached_reg)
        begin
            out_ang_next = '0;
            out_lin_next = '0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= ITER_STAGES; k++)
            begin
                it_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= s_axis_tvalid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (it_en[0])
            begin
                it_valid_reg[0] <= b_valid_reg;
            end
            for (int k = 1; k <= ITER_STAGES; k++)
            begin
                if (it_en[k])
                begin
                    it_valid_reg[k] <= it_valid_reg[k-1];
                end
            end
            if (en_d)
            begin
                d_valid_reg <= it_valid_reg[ITER_STAGES];
            end
            if (en_e)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (en_f)
            begin
                out_valid_reg <= e_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_dx_reg <= a_dx_next;
            a_dy_reg <= a_dy_next;
            a_hd_reg <= pose_heading;
        end
        if (en_b)
        begin
            b_sq_reg <= b_sq_next;
            b_x_reg  <= b_x_next;
            b_y_reg  <= b_y_next;
            b_z_reg  <= b_z_next;
            b_hd_reg <= a_hd_reg;
        end
        if (it_en[0])
        begin
            it_x_reg[0]       <= b_x_reg;
            it_y_reg[0]       <= b_y_reg;
            it_z_reg[0]       <= b_z_reg;
            it_rem_reg[0]     <= b_sq_reg;
            it_root_reg[0]    <= '0;
            it_reached_reg[0] <= reached_next;
            it_hd_reg[0]      <= b_hd_reg;
        end
        for (int k = 1; k <= ITER_STAGES; k++)
        begin
            if (it_en[k])
            begin
                it_x_reg[k]       <= it_x_next[k];
                it_y_reg[k]       <= it_y_next[k];
                it_z_reg[k]       <= it_z_next[k];
                it_rem_reg[k]     <= it_rem_next[k];
                it_root_reg[k]    <= it_root_next[k];
                it_reached_reg[k] <= it_reached_reg[k-1];
                it_hd_reg[k]      <= it_hd_reg[k-1];
            end
        end
        if (en_d)
        begin
            d_lin_prod_reg <= d_lin_prod_next;
            d_err_reg      <= d_err_next;
            d_reached_reg  <= it_reached_reg[ITER_STAGES];
        end
        if (en_e)
        begin
            e_lin_reg      <= e_lin_next;
            e_ang_prod_reg <= e_ang_prod_next;
            e_reached_reg  <= d_reached_reg;
        end
        if (en_f)
        begin
            out_lin_reg     <= out_lin_next;
            out_ang_reg     <= out_ang_next;
            out_reached_reg <= e_reached_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_ang_reg, out_lin_reg};
    assign m_axis_tuser  = out_reached_reg;

endmodule

@@ design/gtg_chk.sv @@
// port-level checks for the go-to-goal steering block
module gtg_chk
    import gtg_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // a reached result commands no motion
    a_reached_still: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[LIN_W+ANG_W-1:0] == '0)
        else $error("reached result with nonzero speed");

    // with the output free to move, a request is always taken
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output can drain");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind go_to_goal_steering gtg_chk u_gtg_chk (.*);
